// ----- design/pps_pkg.sv -----
// Package for the PWM period/duty setter: shared types and constants.
// Used by pps_ctrl, pps_dpath and pwm_period_duty_setter_core; no dependencies.
package pps_pkg;

    // Iteration counts of the divider and the divide-by-100 stage
    localparam int DIV_STEPS  = 32;
    localparam int D100_BITS  = 8;
    localparam int PROD_W     = 40;
    localparam int D100_STEPS = PROD_W / D100_BITS;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [7:0]  DUTY_SCALE = 8'd100;
    localparam logic [31:0] CLOCK_HZ_RESET = 32'd125000000;

    // Control word bits
    localparam logic [15:0] EN_CH0   = 16'h0001;
    localparam logic [15:0] MS_CH0   = 16'h0080;
    localparam logic [15:0] EN_CH1   = 16'h0100;
    localparam logic [15:0] MS_CH1   = 16'h8000;
    localparam logic [15:0] CH0_BITS = 16'h00FF;
    localparam logic [15:0] CH1_BITS = 16'hFF00;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic d100_step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic freq_zero;
    } t_status;

endpackage

// ----- design/pps_ctrl.sv -----
// Controller for the PWM period/duty setter: sequences load, divide,
// multiply, divide-by-100 and commit. Depends on pps_pkg.
module pps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pps_pkg::t_status i_status,
    output pps_pkg::t_cmd   o_cmd
);
    import pps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_D100,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_commit    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_status.freq_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_D100;
            end
            S_D100: begin
                o_cmd.d100_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(D100_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the output valid until the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/pps_dpath.sv -----
// Datapath for the PWM period/duty setter: clock register, radix-2 divider,
// duty multiply, divide-by-100, control word and result registers. Uses pps_pkg.
module pps_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_channel,
    input  logic [31:0]      i_frequency,
    input  logic [31:0]      i_duty_percent,
    input  pps_pkg::t_cmd    i_cmd,
    output pps_pkg::t_status o_status,
    output logic [31:0]      o_period_ticks,
    output logic [31:0]      o_on_ticks,
    output logic [15:0]      o_control_out,
    output logic             o_timing_written
);
    import pps_pkg::*;

    logic [31:0]       r_clock_hz;
    logic [15:0]       r_ctl;
    logic              r_ch;
    logic              r_written;
    logic [6:0]        r_duty;
    logic [30:0]       r_div;
    logic [30:0]       r_rem;
    logic [31:0]       r_quo;
    logic [PROD_W-1:0] r_prod;
    logic [6:0]        r_rem100;
    logic [31:0]       r_period;
    logic [31:0]       r_out_period;
    logic [31:0]       r_out_on;
    logic [15:0]       r_out_ctl;
    logic              r_out_written;

    logic [6:0]        w_duty_c;
    logic [30:0]       w_div_c;
    logic [31:0]       w_trial;
    logic              w_qbit;
    logic [30:0]       n_rem;
    logic [PROD_W-1:0] n_prod;
    logic [6:0]        n_rem100;
    logic [15:0]       n_ctl;

    assign o_status.freq_zero = (i_frequency == 32'd0);

    // Clamp the request: negative frequency becomes 1, duty to 0..100
    always_comb begin
        w_div_c  = i_frequency[31] ? 31'd1 : i_frequency[30:0];
        w_duty_c = i_duty_percent[6:0];
        if (i_duty_percent[31]) begin
            w_duty_c = 7'd0;
        end else if (i_duty_percent > {24'd0, DUTY_SCALE}) begin
            w_duty_c = DUTY_SCALE[6:0];
        end
    end

    // One restoring divide step per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        w_qbit  = (w_trial >= {1'b0, r_div});
        n_rem   = w_qbit ? 31'(w_trial - {1'b0, r_div}) : w_trial[30:0];
    end

    // Eight bits of the divide by 100 per cycle
    always_comb begin
        logic [7:0] v_part;
        n_rem100 = r_rem100;
        n_prod   = r_prod;
        for (int k = 0; k < D100_BITS; k++) begin
            v_part   = {n_rem100, n_prod[PROD_W-1]};
            n_prod   = {n_prod[PROD_W-2:0], 1'b0};
            if (v_part >= DUTY_SCALE) begin
                v_part    = v_part - DUTY_SCALE;
                n_prod[0] = 1'b1;
            end
            n_rem100 = v_part[6:0];
        end
    end

    // New control word: drop the channel enable, then, for a written timing, set enable plus mark-space
    always_comb begin
        n_ctl = r_ctl & ~(r_ch ? EN_CH1 : EN_CH0);
        if (r_written) begin
            if (r_ch) begin
                n_ctl = (n_ctl & ~CH1_BITS) | EN_CH1 | MS_CH1;
            end else begin
                n_ctl = (n_ctl & ~CH0_BITS) | EN_CH0 | MS_CH0;
            end
        end
    end

    // Configuration and kept control word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RESET;
            r_ctl      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_clock_hz <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_ctl <= n_ctl;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch      <= i_channel;
            r_written <= !o_status.freq_zero;
            r_duty    <= w_duty_c;
            r_div     <= w_div_c;
            r_rem     <= '0;
            r_quo     <= r_clock_hz;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[30:0], w_qbit};
        end
        if (i_cmd.mul) begin
            r_period <= r_quo;
            // Form the full product so that it cannot wrap at 32 bits
            r_prod   <= {8'd0, r_quo} * {33'd0, r_duty};
            r_rem100 <= '0;
        end
        if (i_cmd.d100_step) begin
            r_prod   <= n_prod;
            r_rem100 <= n_rem100;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_period  <= r_written ? r_period : 32'd0;
            r_out_on      <= r_written ? r_prod[31:0] : 32'd0;
            r_out_ctl     <= n_ctl;
            r_out_written <= r_written;
        end
    end

    assign o_period_ticks   = r_out_period;
    assign o_on_ticks       = r_out_on;
    assign o_control_out    = r_out_ctl;
    assign o_timing_written = r_out_written;

endmodule

// ----- design/pwm_period_duty_setter_core.sv -----
// PWM period/duty setter top level. An item with a nonzero frequency passes
// through a 32-step radix-2 divider, one multiply, five divide-by-100 steps and
// commit; a zero frequency goes straight to commit. A new item is taken only once
// the last is committed, and the next item is taken while a result waits.
// Synchronous active-low reset clears the control word and loads clock_hz with
// 125000000. Depends on pps_pkg, pps_ctrl, pps_dpath.
module pwm_period_duty_setter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_channel,
    input  logic [31:0] i_frequency,
    input  logic [31:0] i_duty_percent,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_period_ticks,
    output logic [31:0] o_on_ticks,
    output logic [15:0] o_control_out,
    output logic        o_timing_written
);
    import pps_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequence the work
    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Compute period, high time and control word
    pps_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_channel        (i_channel),
        .i_frequency      (i_frequency),
        .i_duty_percent   (i_duty_percent),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_period_ticks   (o_period_ticks),
        .o_on_ticks       (o_on_ticks),
        .o_control_out    (o_control_out),
        .o_timing_written (o_timing_written)
    );

endmodule
